@@ sv/dvpcap_pkg.sv @@
// dvpcap_pkg: shared constants, phase codes and types for the camera capture block
// no dependencies
package dvpcap_pkg;

  localparam int unsigned CntW = 11;
  localparam int unsigned IdxW = 21;
  localparam int unsigned DataW = 8;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned AddrW = 3;
  localparam int unsigned PDataW = 32;

  localparam logic [CntW-1:0] MaxLinePixels = CntW'(1024);
  localparam logic [CntW-1:0] MaxFrameLines = CntW'(1024);
  localparam logic [CntW-1:0] ResetPixels = CntW'(160);
  localparam logic [CntW-1:0] ResetLines = CntW'(120);

  localparam logic [PhaseW-1:0] PhIdle = 4'd0;
  localparam logic [PhaseW-1:0] PhVsHigh = 4'd1;
  localparam logic [PhaseW-1:0] PhVsLow = 4'd2;
  localparam logic [PhaseW-1:0] PhHsAHigh = 4'd3;
  localparam logic [PhaseW-1:0] PhHsALow = 4'd4;
  localparam logic [PhaseW-1:0] PhHsBHigh = 4'd5;
  localparam logic [PhaseW-1:0] PhB0High = 4'd6;
  localparam logic [PhaseW-1:0] PhB0Low = 4'd7;
  localparam logic [PhaseW-1:0] PhB1High = 4'd8;
  localparam logic [PhaseW-1:0] PhB1Low = 4'd9;
  localparam logic [PhaseW-1:0] PhD0High = 4'd10;
  localparam logic [PhaseW-1:0] PhD0Low = 4'd11;
  localparam logic [PhaseW-1:0] PhD1High = 4'd12;
  localparam logic [PhaseW-1:0] PhD1Low = 4'd13;

  localparam logic RegPixels = 1'b0;
  localparam logic RegLines = 1'b1;

  typedef struct packed {
    logic             action;
    logic             vsync;
    logic             hsync;
    logic             pixel_clock;
    logic [DataW-1:0] pixel_data;
  } item_t;

  typedef struct packed {
    logic [IdxW-1:0]  byte_index;
    logic [DataW-1:0] byte_value;
    logic             frame_last;
  } result_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } rb_stat_t;

  function automatic logic [CntW-1:0] clamp_limit(input logic [CntW-1:0] v,
                                                  input logic [CntW-1:0] maxv);
    logic [CntW-1:0] r;
    r = v;
    if (v == '0) r = CntW'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

@@ sv/dvpcap_ctrl.sv @@
// dvpcap_ctrl: capture sequencer, one registered request per step, at most one result
// depends on dvpcap_pkg
module dvpcap_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  dvpcap_pkg::item_t              item_i,
  input  logic [dvpcap_pkg::CntW-1:0]    pixels_per_line_i,
  input  logic [dvpcap_pkg::CntW-1:0]    lines_per_frame_i,
  output logic                           res_valid_o,
  output dvpcap_pkg::result_t            res_o
);
  import dvpcap_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [CntW-1:0]   pix_q, pix_d, line_q, line_d, ppl, lpf;
  logic [IdxW-1:0]   widx_q, widx_d;
  logic [CntW:0]     pix_inc, line_inc;
  logic              emit, last;

  assign ppl = clamp_limit(pixels_per_line_i, MaxLinePixels);
  assign lpf = clamp_limit(lines_per_frame_i, MaxFrameLines);
  assign pix_inc = {1'b0, pix_q} + (CntW+1)'(1);
  assign line_inc = {1'b0, line_q} + (CntW+1)'(1);

  always_comb begin
    phase_d = phase_q;
    pix_d = pix_q;
    line_d = line_q;
    widx_d = widx_q;
    emit = 1'b0;
    last = 1'b0;
    if (step_i) begin
      if (item_i.action) begin
        if (phase_q == PhIdle) begin
          pix_d = '0;
          line_d = '0;
          widx_d = '0;
          phase_d = PhVsHigh;
        end
      end else begin
        case (phase_q)
          PhVsHigh:  if (item_i.vsync) phase_d = PhVsLow;
          PhVsLow:   if (!item_i.vsync) phase_d = PhHsAHigh;
          PhHsAHigh: if (item_i.hsync) phase_d = PhHsALow;
          PhHsALow:  if (!item_i.hsync) phase_d = PhHsBHigh;
          PhHsBHigh: if (item_i.hsync) phase_d = PhB0High;
          PhB0High: begin
            if (item_i.pixel_clock) begin
              emit = 1'b1;
              phase_d = PhB0Low;
            end
          end
          PhB0Low:   if (!item_i.pixel_clock) phase_d = PhB1High;
          PhB1High: begin
            if (item_i.pixel_clock) begin
              emit = 1'b1;
              last = (pix_inc >= {1'b0, ppl}) && (line_inc >= {1'b0, lpf});
              phase_d = PhB1Low;
            end
          end
          PhB1Low:   if (!item_i.pixel_clock) phase_d = PhD0High;
          PhD0High:  if (item_i.pixel_clock) phase_d = PhD0Low;
          PhD0Low:   if (!item_i.pixel_clock) phase_d = PhD1High;
          PhD1High:  if (item_i.pixel_clock) phase_d = PhD1Low;
          PhD1Low: begin
            if (!item_i.pixel_clock) begin
              if (pix_inc[CntW-1:0] >= ppl) begin
                pix_d = '0;
                if (line_inc[CntW-1:0] >= lpf) begin
                  line_d = '0;
                  phase_d = PhIdle;
                end else begin
                  line_d = line_inc[CntW-1:0];
                  phase_d = PhHsAHigh;
                end
              end else begin
                pix_d = pix_inc[CntW-1:0];
                phase_d = PhB0High;
              end
            end
          end
          PhIdle:    phase_d = PhIdle;
          default:   phase_d = PhIdle;
        endcase
        if (emit) widx_d = widx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pix_q <= '0;
      line_q <= '0;
      widx_q <= '0;
    end else begin
      phase_q <= phase_d;
      pix_q <= pix_d;
      line_q <= line_d;
      widx_q <= widx_d;
    end
  end

  assign res_valid_o = emit;
  assign res_o.byte_index = widx_q;
  assign res_o.byte_value = item_i.pixel_data;
  assign res_o.frame_last = last;

endmodule

@@ sv/dvpcap_rbuf.sv @@
// dvpcap_rbuf: two-entry result buffer between the sequencer and the output channel
// depends on dvpcap_pkg
module dvpcap_rbuf (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  dvpcap_pkg::result_t    push_data_i,
  input  logic                   pop_i,
  output dvpcap_pkg::result_t    head_o,
  output dvpcap_pkg::rb_stat_t   stat_o
);
  import dvpcap_pkg::*;

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 2'd1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_d;
    end
  end

  assign head_o = mem_q[rd_q];
  assign stat_o.full = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.count = cnt_q;

endmodule

@@ sv/dvp_camera_capture_decimator_top.sv @@
// dvp_camera_capture_decimator_top: one-frame decimating capture from a sampled camera bus
// depends on dvpcap_pkg, dvpcap_ctrl, dvpcap_rbuf
//
//   channel  | handshake                | payload
//   ---------+--------------------------+--------------------------------------------
//   in       | in_valid_i / in_stall_o  | action, vsync, hsync, pixel_clock, pixel_data
//   out      | out_valid_o / out_stall_i| byte_index, byte_value, frame_last
//   config   | apb psel/penable/pwrite  | pixels_per_line @0x0, lines_per_frame @0x4
//
// one request per cycle unless stalled: input register, sequencer step, two-entry result buffer
// a result is offered on the output once the step of its registered request writes it into the result buffer
// input stalls only while the result buffer holds two results and a request waits
// reset clears the sequencer to idle and restores 160 pixels, 120 lines
module dvp_camera_capture_decimator_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic                     vsync_i,
  input  logic                     hsync_i,
  input  logic                     pixel_clock_i,
  input  logic [7:0]               pixel_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [20:0]              byte_index_o,
  output logic [7:0]               byte_value_o,
  output logic                     frame_last_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import dvpcap_pkg::*;

  logic            s1_valid_q, s1_valid_d, in_acc, s1_go, res_valid, pop;
  item_t           s1_q;
  logic [CntW-1:0] ppl_q, lpf_q;
  result_t         res, head;
  rb_stat_t        rb_stat;

  assign in_stall_o = s1_valid_q && rb_stat.full;
  assign in_acc = in_valid_i && !in_stall_o;
  assign s1_go = s1_valid_q && !rb_stat.full;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) s1_valid_d = 1'b1;
    else if (s1_go) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else s1_valid_q <= s1_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q.action <= action_i;
      s1_q.vsync <= vsync_i;
      s1_q.hsync <= hsync_i;
      s1_q.pixel_clock <= pixel_clock_i;
      s1_q.pixel_data <= pixel_data_i;
    end
  end

  // config registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppl_q <= ResetPixels;
      lpf_q <= ResetLines;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == RegPixels) ppl_q <= pwdata[CntW-1:0];
      else lpf_q <= pwdata[CntW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegLines) ? PDataW'(lpf_q) : PDataW'(ppl_q);

  dvpcap_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (s1_go),
    .item_i            (s1_q),
    .pixels_per_line_i (ppl_q),
    .lines_per_frame_i (lpf_q),
    .res_valid_o       (res_valid),
    .res_o             (res)
  );

  assign pop = out_valid_o && !out_stall_i;

  dvpcap_rbuf u_rbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (rb_stat)
  );

  assign out_valid_o = !rb_stat.empty;
  assign byte_index_o = head.byte_index;
  assign byte_value_o = head.byte_value;
  assign frame_last_o = head.frame_last;

  a_rb_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rb_stat.count != 2'd3)
    else $error("result buffer count out of range");

  a_result_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (s1_go && !rb_stat.full))
    else $error("result produced without a step");

  a_stall_holds_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> s1_valid_q)
    else $error("stalled with no request pending");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !pop) |=> !rb_stat.empty)
    else $error("pushed result lost");

endmodule

@@ dv/tb_dvp_camera_capture_decimator_top.sv @@
// tb_dvp_camera_capture_decimator_top: self-checking bench for the decimating frame capture
// directed table, clamped-limit frames, then randomized camera frames, scored against a cycle-free capture predictor
// depends on dvpcap_pkg and dvp_camera_capture_decimator_top
module tb_dvp_camera_capture_decimator_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dvpcap_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned RandomTarget = 1000;
  localparam int unsigned QuietAfter = 900;
  localparam int unsigned MaxShown = 10;
  localparam int unsigned ShortCut = 4;
  localparam int unsigned NoCut = 32'hFFFF_FFFF;

  typedef enum logic {RowItem, RowWrite} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    item_t       req;
    logic        reg_sel;
    logic [31:0] value;
    bit          typed;
    result_t     want;
  } stim_row_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              action_i = 1'b0;
  logic              vsync_i = 1'b0;
  logic              hsync_i = 1'b0;
  logic              pixel_clock_i = 1'b0;
  logic [7:0]        pixel_data_i = 8'h00;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [20:0]       byte_index_o;
  logic [7:0]        byte_value_o;
  logic              frame_last_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = 3'b000;
  logic [31:0]       pwdata = 32'h0;
  logic [31:0]       prdata;
  logic              pready;

  logic [CntW-1:0]   pixels_cfg = ResetPixels;
  logic [CntW-1:0]   lines_cfg = ResetLines;
  logic [PhaseW-1:0] cap_phase = PhIdle;
  logic [CntW-1:0]   pixel_cnt = '0;
  logic [CntW-1:0]   line_cnt = '0;
  logic [IdxW-1:0]   wr_index = '0;

  result_t           frame_bytes[$];
  int unsigned       mismatches = 0;
  int unsigned       samples_sent = 0;
  int unsigned       stuck_cycles = 0;
  int unsigned       gap_pct = 0;
  int unsigned       stall_pct = 0;
  int                stall_left = 0;
  bit                quiet = 1'b0;

  dvp_camera_capture_decimator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .vsync_i       (vsync_i),
    .hsync_i       (hsync_i),
    .pixel_clock_i (pixel_clock_i),
    .pixel_data_i  (pixel_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_index_o  (byte_index_o),
    .byte_value_o  (byte_value_o),
    .frame_last_o  (frame_last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned limit_of(input logic [CntW-1:0] v,
                                           input logic [CntW-1:0] maxv);
    if (v == '0) return 1;
    if (v > maxv) return 32'(maxv);
    return 32'(v);
  endfunction

  function automatic bit predict_capture(input item_t req, output result_t res);
    int unsigned ppl_eff;
    int unsigned lpf_eff;
    bit          produced;
    ppl_eff = limit_of(pixels_cfg, MaxLinePixels);
    lpf_eff = limit_of(lines_cfg, MaxFrameLines);
    produced = 1'b0;
    res = '0;
    if (req.action) begin
      if (cap_phase == PhIdle) begin
        pixel_cnt = '0;
        line_cnt = '0;
        wr_index = '0;
        cap_phase = PhVsHigh;
      end
      return 1'b0;
    end
    case (cap_phase)
      PhVsHigh: if (req.vsync) cap_phase = PhVsLow;
      PhVsLow: if (!req.vsync) cap_phase = PhHsAHigh;
      PhHsAHigh: if (req.hsync) cap_phase = PhHsALow;
      PhHsALow: if (!req.hsync) cap_phase = PhHsBHigh;
      PhHsBHigh: if (req.hsync) cap_phase = PhB0High;
      PhB0High: if (req.pixel_clock) begin
        res.byte_index = wr_index;
        res.byte_value = req.pixel_data;
        res.frame_last = 1'b0;
        wr_index = wr_index + 21'd1;
        produced = 1'b1;
        cap_phase = PhB0Low;
      end
      PhB0Low: if (!req.pixel_clock) cap_phase = PhB1High;
      PhB1High: if (req.pixel_clock) begin
        res.byte_index = wr_index;
        res.byte_value = req.pixel_data;
        res.frame_last = (32'(pixel_cnt) + 1 >= ppl_eff) && (32'(line_cnt) + 1 >= lpf_eff);
        wr_index = wr_index + 21'd1;
        produced = 1'b1;
        cap_phase = PhB1Low;
      end
      PhB1Low: if (!req.pixel_clock) cap_phase = PhD0High;
      PhD0High: if (req.pixel_clock) cap_phase = PhD0Low;
      PhD0Low: if (!req.pixel_clock) cap_phase = PhD1High;
      PhD1High: if (req.pixel_clock) cap_phase = PhD1Low;
      PhD1Low: if (!req.pixel_clock) begin
        pixel_cnt = pixel_cnt + 11'd1;
        if (32'(pixel_cnt) >= ppl_eff) begin
          pixel_cnt = '0;
          line_cnt = line_cnt + 11'd1;
          if (32'(line_cnt) >= lpf_eff) begin
            line_cnt = '0;
            cap_phase = PhIdle;
          end else begin
            cap_phase = PhHsAHigh;
          end
        end else begin
          cap_phase = PhB0High;
        end
      end
      default: cap_phase = PhIdle;
    endcase
    return produced;
  endfunction

  function automatic stim_row_t mk_item(input logic a, input logic vs, input logic hs,
                                        input logic pc, input logic [7:0] d);
    stim_row_t r;
    r.kind = RowItem;
    r.req = '{a, vs, hs, pc, d};
    r.reg_sel = 1'b0;
    r.value = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t mk_byte(input logic vs, input logic hs, input logic [7:0] d,
                                        input logic [IdxW-1:0] idx, input logic last);
    stim_row_t r;
    r = mk_item(1'b0, vs, hs, 1'b1, d);
    r.typed = 1'b1;
    r.want = '{idx, d, last};
    return r;
  endfunction

  function automatic stim_row_t mk_write(input logic sel, input logic [31:0] value);
    stim_row_t r;
    r = mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    r.kind = RowWrite;
    r.reg_sel = sel;
    r.value = value;
    return r;
  endfunction

  function automatic int unsigned burst_rate();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 5;
      default: return 25;
    endcase
  endfunction

  function automatic logic [CntW-1:0] small_limit();
    if ($urandom_range(0, 9) == 0) return '0;
    return CntW'($urandom_range(1, 4));
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= MaxShown) begin
      $display("%s: expected index %0d value %02h last %0d, got index %0d value %02h last %0d",
               what, want.byte_index, want.byte_value, want.frame_last,
               got.byte_index, got.byte_value, got.frame_last);
    end
  endtask

  task automatic send_sample(input item_t req, input bit typed, input result_t want);
    result_t predicted;
    bit      has_byte;
    if (samples_sent >= QuietAfter) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= req.action;
    vsync_i <= req.vsync;
    hsync_i <= req.hsync;
    pixel_clock_i <= req.pixel_clock;
    pixel_data_i <= req.pixel_data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    has_byte = predict_capture(req, predicted);
    if (typed) frame_bytes.push_back(want);
    else if (has_byte) frame_bytes.push_back(predicted);
    samples_sent++;
  endtask

  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    while (frame_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == RegPixels) pixels_cfg = value[CntW-1:0];
    else lines_cfg = value[CntW-1:0];
  endtask

  task automatic drive_level(input logic vs, input logic hs, input logic pc,
                             input int unsigned rep);
    item_t s;
    repeat ($urandom_range(1, rep)) begin
      if ($urandom_range(0, 31) == 0) begin
        s = item_t'(12'($urandom()));
        s.action = ($urandom_range(0, 7) == 0);
        send_sample(s, 1'b0, '0);
      end
      s = '{1'b0, vs, hs, pc, 8'($urandom())};
      send_sample(s, 1'b0, '0);
    end
  endtask

  task automatic run_frame(input int unsigned rep, input bit may_cut, input int unsigned cap);
    int unsigned lines;
    int unsigned pixels;
    int unsigned cut;
    int unsigned done;
    item_t       arm;
    lines = limit_of(lines_cfg, MaxFrameLines);
    pixels = limit_of(pixels_cfg, MaxLinePixels);
    cut = lines * pixels;
    if (may_cut && $urandom_range(0, 7) == 0) cut = $urandom_range(0, lines * pixels);
    if (cut > cap) cut = cap;
    done = 0;
    arm = item_t'(12'($urandom()));
    arm.action = 1'b1;
    send_sample(arm, 1'b0, '0);
    drive_level(1'b0, 1'b0, 1'b0, rep);
    drive_level(1'b1, 1'b0, 1'b0, rep);
    drive_level(1'b0, 1'b0, 1'b0, rep);
    for (int unsigned l = 0; l < lines; l++) begin
      drive_level(1'b0, 1'b1, 1'b0, rep);
      drive_level(1'b0, 1'b0, 1'b0, rep);
      drive_level(1'b0, 1'b1, 1'b0, rep);
      for (int unsigned p = 0; p < pixels; p++) begin
        if (done == cut) return;
        repeat (4) begin
          drive_level(1'b0, 1'b1, 1'b1, rep);
          drive_level(1'b0, 1'b1, 1'b0, rep);
        end
        done++;
      end
    end
  endtask

  always @(posedge clk_i) begin : byte_sink
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{byte_index_o, byte_value_o, frame_last_o};
        if (frame_bytes.size() == 0) begin
          report_mismatch("byte with nothing pending", '0, got);
        end else begin
          want = frame_bytes.pop_front();
          if (got.byte_index !== want.byte_index || got.byte_value !== want.byte_value ||
              got.frame_last !== want.frame_last) begin
            report_mismatch("byte mismatch", want, got);
          end
        end
      end
      if (!quiet && stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= IdleLimit) begin
        $display("dvp_camera_capture_decimator_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   rows[$];
    int unsigned frame_no;
    // idle sample, arm, ignored re-arm, one pixel at reset sizes, then shrink mid-frame
    rows.push_back(mk_item(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF));
    rows.push_back(mk_item(1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    rows.push_back(mk_item(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
    rows.push_back(mk_item(1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
    rows.push_back(mk_byte(1'b0, 1'b1, 8'h00, 21'd0, 1'b0));
    rows.push_back(mk_item(1'b0, 1'b1, 1'b1, 1'b0, 8'hA5));
    rows.push_back(mk_byte(1'b0, 1'b1, 8'hFF, 21'd1, 1'b0));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
    rows.push_back(mk_write(RegPixels, 32'd1));
    rows.push_back(mk_write(RegLines, 32'd1));
    rows.push_back(mk_byte(1'b0, 1'b0, 8'h5A, 21'd2, 1'b0));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    rows.push_back(mk_byte(1'b0, 1'b0, 8'hA5, 21'd3, 1'b1));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b0, 1'b0, 1'b0, 8'h00));
    rows.push_back(mk_item(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == RowWrite) begin
        settle_pipeline();
        write_reg(rows[i].reg_sel, rows[i].value);
      end else begin
        send_sample(rows[i].req, rows[i].typed, rows[i].want);
      end
    end

    // line above the pixel maximum with zero lines, then one-pixel lines above the
    // line maximum, both cut after a few pixels
    gap_pct = burst_rate();
    stall_pct = burst_rate();
    settle_pipeline();
    write_reg(RegPixels, 32'd2047);
    write_reg(RegLines, 32'd0);
    run_frame(1, 1'b0, ShortCut);
    settle_pipeline();
    write_reg(RegPixels, 32'd0);
    write_reg(RegLines, 32'd2047);
    run_frame(1, 1'b0, ShortCut);
    settle_pipeline();
    write_reg(RegPixels, {21'($urandom()), small_limit()});
    write_reg(RegLines, {21'($urandom()), small_limit()});

    frame_no = 0;
    while (samples_sent < RandomTarget) begin
      gap_pct = burst_rate();
      stall_pct = burst_rate();
      if (frame_no != 0 && $urandom_range(0, 2) == 0) begin
        settle_pipeline();
        if ($urandom_range(0, 1) == 0) write_reg(RegPixels, {21'($urandom()), small_limit()});
        else write_reg(RegLines, {21'($urandom()), small_limit()});
      end
      run_frame(3, 1'b1, NoCut);
      frame_no++;
    end

    quiet = 1'b1;
    settle_pipeline();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && frame_bytes.size() == 0) begin
      $display("dvp_camera_capture_decimator_top verification clean");
    end else begin
      $display("dvp_camera_capture_decimator_top verification failed");
    end
    $finish;
  end

endmodule
